// ===== hw/rtl/fp16_fp32_convert_unit_macros.svh =====
// assertion macros for the fp16/fp32 convert unit
`ifndef FP16_FP32_CONVERT_UNIT_MACROS_SVH
`define FP16_FP32_CONVERT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== hw/rtl/fpcvt_pkg.sv =====
package fpcvt_pkg;
  localparam logic [15:0] HALF_INF = 16'h7c00;
  localparam logic [31:0] SINGLE_INF = 32'h7f800000;
  localparam logic [1:0] ADDR_DIRECTION = 2'd0;

  typedef struct packed {
    logic [31:0] bits;
    logic        nan;
  } conv_result_t;
endpackage

// ===== hw/rtl/fp16_fp32_convert_unit.sv =====
// channel  | signals                                  | role
// input    | source_valid, source_ready, source_bits  | one value per transaction
// output   | result_valid, result_ready, result_bits,  | converted value and nan flag
//          | nan_error                                |
// config   | psel..prdata (apb)                       | direction register at 0x0
//
// the result register loads from the input register through the single combinational conversion
// stage between them; one transaction per clock sustained while result_ready does not stall
// a two-entry pipe (input stage, result stage) lets the input take a new
// transaction while a finished result waits on result_ready
// rst is synchronous, active high; clears valids and direction
`include "fp16_fp32_convert_unit_macros.svh"
module fp16_fp32_convert_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        source_valid,
  output logic        source_ready,
  input  logic [31:0] source_bits,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] result_bits,
  output logic        nan_error
);
  logic                       direction;
  // input stage
  logic                       in_valid;
  logic [31:0]                in_bits;
  logic                       in_dir;
  logic                       in_advance;
  fpcvt_pkg::conv_result_t    h2s_res;
  fpcvt_pkg::conv_result_t    s2h_res;
  fpcvt_pkg::conv_result_t    conv;

  assign pready = 1'b1;
  assign prdata = (paddr == fpcvt_pkg::ADDR_DIRECTION) ? {31'd0, direction} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (psel && penable && pwrite && paddr == fpcvt_pkg::ADDR_DIRECTION) begin
      direction <= pwdata[0];
    end
  end

  // result stage moves when empty or being drained
  assign in_advance = !result_valid || result_ready;
  assign source_ready = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (source_ready) begin
      in_valid <= source_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (source_ready && source_valid) begin
      in_bits <= source_bits;
      in_dir <= direction;
    end
  end

  fpcvt_h2s u_h2s (.h(in_bits[15:0]), .res(h2s_res));
  fpcvt_s2h u_s2h (.s(in_bits), .res(s2h_res));

  assign conv = in_dir ? s2h_res : h2s_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (in_advance) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && in_valid) begin
      result_bits <= conv.bits;
      nan_error <= conv.nan;
    end
  end

  `ASSERT_IMPLIES(a_nan_zero, clk, rst, result_valid && nan_error, result_bits == 32'd0)
  `ASSERT_NEXT(a_hold, clk, rst, result_valid && !result_ready,
               result_valid && $stable(result_bits) && $stable(nan_error))
  `ASSERT_NEXT(a_flow, clk, rst, in_valid && in_advance, result_valid)
endmodule

// ===== hw/rtl/fpcvt_h2s.sv =====
module fpcvt_h2s (
  input  logic [15:0]                 h,
  output fpcvt_pkg::conv_result_t     res
);
  logic        sign;
  logic [4:0]  e;
  logic [9:0]  f;
  logic [3:0]  lz;
  logic [9:0]  fn;
  logic [7:0]  ue;

  always_comb begin
    lz = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (f[i] && lz == 4'd0 && (f >> (i + 1)) == 10'd0) lz = 4'(9 - i);
    end
  end

  assign sign = h[15];
  assign e = h[14:10];
  assign f = h[9:0];
  assign fn = f << (lz + 4'd1);
  assign ue = 8'd112 - 8'(lz);

  always_comb begin
    res.nan = 1'b0;
    if (e == 5'd0) begin
      if (f == 10'd0) res.bits = {sign, 31'd0};
      else res.bits = {sign, ue, fn, 13'd0};
    end else if (e == 5'd31) begin
      if (f != 10'd0) begin
        res.bits = 32'd0;
        res.nan = 1'b1;
      end else begin
        res.bits = {sign, 31'd0} | fpcvt_pkg::SINGLE_INF;
      end
    end else begin
      res.bits = {sign, 8'({3'd0, e} + 8'd112), f, 13'd0};
    end
  end
endmodule

// ===== hw/rtl/fpcvt_s2h.sv =====
module fpcvt_s2h (
  input  logic [31:0]                 s,
  output fpcvt_pkg::conv_result_t     res
);
  logic        sign;
  logic [7:0]  eb;
  logic [22:0] f;
  logic [9:0]  df;
  logic [12:0] rem;
  logic        up;
  logic [15:0] norm;
  logic [4:0]  sh;
  logic [23:0] sig;
  logic [23:0] sub_df;
  logic [23:0] sub_rem;
  logic [23:0] sub_half;
  logic        sub_up;
  logic [15:0] inf_h;

  assign sign = s[31];
  assign eb = s[30:23];
  assign f = s[22:0];
  assign inf_h = {sign, 15'd0} | fpcvt_pkg::HALF_INF;
  assign df = f[22:13];
  assign rem = f[12:0];
  assign up = rem > 13'h1000 || (rem == 13'h1000 && df[0]);
  // rounding overflow into next exponent falls out of the add
  assign norm = {sign, 15'({5'(eb - 8'd112), df} + 15'(up))};
  assign sig = {1'b1, f};
  assign sh = 5'(8'd126 - eb);
  assign sub_df = sig >> sh;
  assign sub_rem = sig & ((24'd1 << sh) - 24'd1);
  assign sub_half = 24'd1 << (sh - 5'd1);
  assign sub_up = sub_rem > sub_half || (sub_rem == sub_half && sub_df[0]);

  always_comb begin
    res.nan = 1'b0;
    res.bits = 32'd0;
    if (eb == 8'hff) begin
      if (f != 23'd0) res.nan = 1'b1;
      else res.bits = {16'd0, inf_h};
    end else if (eb > 8'd142) begin
      res.bits = {16'd0, inf_h};
    end else if (eb >= 8'd113) begin
      if (norm[14:10] == 5'd31) res.bits = {16'd0, inf_h};
      else res.bits = {16'd0, norm};
    end else if (eb < 8'd102) begin
      res.bits = {16'd0, sign, 15'd0};
    end else begin
      res.bits = {16'd0, sign, 15'(sub_df[10:0] + 11'(sub_up))};
    end
  end
endmodule

// ===== tb/fp_convert_checker.sv =====
module fp_convert_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        source_valid,
  input  logic        source_ready,
  input  logic [31:0] source_bits,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [31:0] result_bits,
  input  logic        nan_error,
  output int          mismatch_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                    single_to_half_mode;
  // ring of predicted results, indexed by the low bits of the running counts
  fpcvt_pkg::conv_result_t expected_mem [16];
  int                      stored_count;
  int                      checked_count;

  function automatic fpcvt_pkg::conv_result_t widen_half(logic [15:0] h);
    fpcvt_pkg::conv_result_t r;
    logic [4:0]  e;
    logic [9:0]  f;
    logic [31:0] sgn;
    int          ue;
    e   = h[14:10];
    f   = h[9:0];
    sgn = {h[15], 31'b0};
    r.nan = 1'b0;
    if (e == 5'd0) begin
      if (f == 10'd0) begin
        r.bits = sgn;
      end else begin
        ue = -14;
        while (!f[9]) begin
          f = f << 1;
          ue--;
        end
        // leading one drops out, remaining fraction shifts up
        f = f << 1;
        ue--;
        r.bits = sgn | (32'(ue + 127) << 23) | (32'(f) << 13);
      end
    end else if (e == 5'h1f) begin
      if (f != 10'd0) begin
        r.nan  = 1'b1;
        r.bits = 32'd0;
      end else begin
        r.bits = sgn | fpcvt_pkg::SINGLE_INF;
      end
    end else begin
      r.bits = sgn | (32'(e + 8'd112) << 23) | (32'(f) << 13);
    end
    return r;
  endfunction

  function automatic fpcvt_pkg::conv_result_t narrow_single(logic [31:0] s);
    fpcvt_pkg::conv_result_t r;
    logic [15:0] sgn;
    logic [22:0] f;
    logic [31:0] sig, df, rem, hlf, de;
    int          ex, sh;
    sgn = {s[31], 15'b0};
    f   = s[22:0];
    ex  = int'(s[30:23]) - 127;
    r.nan = 1'b0;
    if (s[30:23] == 8'hff) begin
      r.nan  = (f != 23'd0);
      r.bits = r.nan ? 32'd0 : {16'd0, sgn | fpcvt_pkg::HALF_INF};
    end else if (ex > 15) begin
      r.bits = {16'd0, sgn | fpcvt_pkg::HALF_INF};
    end else if (ex >= -14) begin
      de  = 32'(ex + 15);
      df  = 32'(f >> 13);
      rem = 32'(f[12:0]);
      if (rem > 32'h1000 || (rem == 32'h1000 && df[0])) begin
        df++;
        if (df == 32'h400) begin
          df = 0;
          de++;
        end
      end
      if (de >= 32'h1f) r.bits = {16'd0, sgn | fpcvt_pkg::HALF_INF};
      else r.bits = {16'd0, sgn | 16'(de << 10) | 16'(df)};
    end else if (ex < -25) begin
      r.bits = {16'd0, sgn};
    end else begin
      sig = {9'd1, f};
      sh  = -ex - 1;
      df  = sig >> sh;
      rem = sig & ((32'd1 << sh) - 1);
      hlf = 32'd1 << (sh - 1);
      if (rem > hlf || (rem == hlf && df[0])) df++;
      r.bits = {16'd0, sgn | 16'(df)};
    end
    return r;
  endfunction

  assign pending_count = stored_count - checked_count;

  always @(posedge clk) begin
    fpcvt_pkg::conv_result_t want;
    if (rst) begin
      single_to_half_mode <= 1'b0;
      mismatch_count      <= 0;
      stored_count        <= 0;
      checked_count       <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == fpcvt_pkg::ADDR_DIRECTION)
        single_to_half_mode <= pwdata[0];
      if (source_valid && source_ready) begin
        expected_mem[stored_count[3:0]] <= single_to_half_mode ?
                                           narrow_single(source_bits) :
                                           widen_half(source_bits[15:0]);
        stored_count <= stored_count + 1;
      end
      if (result_valid && result_ready) begin
        if (stored_count == checked_count) begin
          if (mismatch_count < 10)
            $display("unexpected result transaction: %h nan %b", result_bits, nan_error);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_mem[checked_count[3:0]];
          checked_count <= checked_count + 1;
          if (want.bits !== result_bits || want.nan !== nan_error) begin
            if (mismatch_count < 10)
              $display("mismatch: expected %h nan %b, got %h nan %b",
                       want.bits, want.nan, result_bits, nan_error);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        source_valid = 1'b0;
  logic        source_ready;
  logic [31:0] source_bits = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] result_bits;
  logic        nan_error;
  int          mismatch_count, pending_count;
  int          idle_cycles;
  bit          calm_tail;  // no idling in the last part of the run

  localparam int WATCHDOG_LIMIT = 2000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fp16_fp32_convert_unit dut (.*);

  fp_convert_checker checker_i (.*);

  // watchdog: cycles in which no transaction moves on any channel
  always @(posedge clk) begin
    if (rst || (source_valid && source_ready) || (result_valid && result_ready) ||
        (psel && penable))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("fp16_fp32_convert_unit test failed");
        $finish;
      end
    end
  end

  // receiver side: random stall bursts, with runs of no stall
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(negedge clk);
      end
      result_ready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(negedge clk);
    end
  end

  // apb write: setup cycle then access cycle, pready is tied high
  task automatic write_direction(logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= fpcvt_pkg::ADDR_DIRECTION;
    pwdata  <= value;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one source transaction, with an optional random gap before it
  task automatic send_value(logic [31:0] value, bit allow_gap);
    int n;
    if (allow_gap && !calm_tail && $urandom_range(0, 4) == 0) begin
      source_valid <= 1'b0;
      n = $urandom_range(1, 11);
      repeat (n) @(negedge clk);
    end
    source_valid <= 1'b1;
    source_bits  <= value;
    @(posedge clk);
    while (!source_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait for every expected result, then let the pipe settle
  task automatic drain_results();
    source_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] random_single();
    logic [7:0] e;
    case ($urandom_range(0, 7))
      0:       e = 8'hff;
      1:       e = 8'h00;
      2:       e = 8'(110 + $urandom_range(0, 5));  // around the half subnormal boundary
      3:       e = 8'(141 + $urandom_range(0, 3));  // near half overflow
      4:       e = 8'(90 + $urandom_range(0, 25));  // flush and tiny range
      default: e = 8'($urandom_range(112, 142));
    endcase
    if ($urandom_range(0, 3) == 0)
      return {$urandom_range(0, 1) == 1, e, 10'($urandom), 13'h1000};  // ties
    return {$urandom_range(0, 1) == 1, e, 23'($urandom)};
  endfunction

  function automatic logic [31:0] random_half();
    logic [4:0] e;
    case ($urandom_range(0, 5))
      0:       e = 5'h1f;
      1:       e = 5'h00;
      default: e = 5'($urandom);
    endcase
    return {16'($urandom), $urandom_range(0, 1) == 1, e, 10'($urandom)};
  endfunction

  initial begin
    logic [31:0] half_cases[$];
    logic [31:0] single_cases[$];
    half_cases = '{32'h0000_0000, 32'hffff_8000, 32'h0000_0001, 32'h0000_83ff,
                   32'h1234_0200, 32'h0000_0400, 32'hffff_7bff, 32'h0000_7c00,
                   32'h0000_fc00, 32'h0000_7c01, 32'hffff_ffff};
    single_cases = '{32'h0000_0000, 32'h8000_0000, 32'h007f_ffff, 32'h7f80_0000,
                     32'hff80_0000, 32'h7fc0_0000, 32'h477f_e000, 32'h477f_f000,
                     32'h4780_0000, 32'h387f_f000, 32'h3380_0000, 32'h3300_0000,
                     32'h3300_0001, 32'h3f80_1000, 32'h3f80_3000};

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: half to single at reset direction, then written explicitly
    foreach (half_cases[i]) send_value(half_cases[i], 1'b0);
    drain_results();
    write_direction(32'hffff_fffe);  // bit 0 clear keeps half to single
    write_direction(32'h0000_0003);  // only bit 0 taken
    foreach (single_cases[i]) send_value(single_cases[i], 1'b0);
    drain_results();

    // random phases alternating direction
    for (int phase = 0; phase < 6; phase++) begin
      write_direction({31'($urandom), phase[0] == 1'b0});
      if (phase == 5) calm_tail = 1'b1;
      for (int k = 0; k < 105; k++)
        send_value(phase[0] ? random_half() : random_single(), 1'b1);
      drain_results();
    end

    if (mismatch_count == 0)
      $display("fp16_fp32_convert_unit test passed");
    else
      $display("fp16_fp32_convert_unit test failed");
    $finish;
  end
endmodule
